// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. The clock is clk and the reset is rst
// in every module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QMEG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QMEG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QMEG_ASSERT(lbl, prop, msg)
`define QMEG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/qmeg_pkg.sv
// ----------------------------------------------------------------------------
// qmeg_pkg: shared types and constants
// Flag codes, register indexes and the item descriptor that moves from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package qmeg_pkg;

  localparam int IdW   = 20;
  localparam int PermW = 32;

  localparam logic [1:0] REG_GRID_ROWS     = 2'd0;
  localparam logic [1:0] REG_GRID_COLS     = 2'd1;
  localparam logic [1:0] REG_HARMONIC_MODE = 2'd2;

  localparam logic [3:0] FLAG_NONE   = 4'd0;
  localparam logic [3:0] FLAG_TOP    = 4'd1;
  localparam logic [3:0] FLAG_BOTTOM = 4'd2;
  localparam logic [3:0] FLAG_LEFT   = 4'd3;
  localparam logic [3:0] FLAG_RIGHT  = 4'd4;
  localparam logic [3:0] FLAG_LL     = 4'd5;
  localparam logic [3:0] FLAG_LR     = 4'd6;
  localparam logic [3:0] FLAG_UR     = 4'd7;
  localparam logic [3:0] FLAG_UL     = 4'd8;

  typedef struct packed {
    logic [IdW-1:0] element_id;
    logic [IdW-1:0] vertex_lower_left;
    logic [IdW-1:0] vertex_lower_right;
    logic [IdW-1:0] vertex_upper_right;
    logic [IdW-1:0] vertex_upper_left;
    logic [15:0]    node_flags;
    logic [3:0]     outside_mask;
    logic [IdW-1:0] neighbour_bottom;
    logic [IdW-1:0] neighbour_right;
    logic [IdW-1:0] neighbour_top;
    logic [IdW-1:0] neighbour_left;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic             harmonic;
    logic [PermW-1:0] ul;
    logic [PermW-1:0] ll;
    logic [PermW-1:0] lr;
    logic [PermW-1:0] ur;
  } desc_t;

endpackage

// File: hw/rtl/qmeg_if.sv
// ----------------------------------------------------------------------------
// qmeg_in_if / qmeg_out_if: element stream channels
// Valid/ready channels for the corner values and for the element records.
// ----------------------------------------------------------------------------
interface qmeg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] perm_upper_left;
  logic [31:0] perm_lower_left;
  logic [31:0] perm_lower_right;
  logic [31:0] perm_upper_right;

  modport source(output valid, perm_upper_left, perm_lower_left, perm_lower_right,
                 perm_upper_right, input ready);
  modport sink(input valid, perm_upper_left, perm_lower_left, perm_lower_right,
               perm_upper_right, output ready);
endinterface

interface qmeg_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] element_id;
  logic [31:0] element_perm;
  logic [19:0] vertex_lower_left;
  logic [19:0] vertex_lower_right;
  logic [19:0] vertex_upper_right;
  logic [19:0] vertex_upper_left;
  logic [15:0] node_flags;
  logic [3:0]  outside_mask;
  logic [19:0] neighbour_bottom;
  logic [19:0] neighbour_right;
  logic [19:0] neighbour_top;
  logic [19:0] neighbour_left;

  modport source(output valid, element_id, element_perm, vertex_lower_left,
                 vertex_lower_right, vertex_upper_right, vertex_upper_left, node_flags,
                 outside_mask, neighbour_bottom, neighbour_right, neighbour_top,
                 neighbour_left, input ready);
  modport sink(input valid, element_id, element_perm, vertex_lower_left,
               vertex_lower_right, vertex_upper_right, vertex_upper_left, node_flags,
               outside_mask, neighbour_bottom, neighbour_right, neighbour_top,
               neighbour_left, output ready);
endinterface

// File: hw/rtl/qmeg_queue.sv
// ----------------------------------------------------------------------------
// qmeg_queue: two-entry descriptor queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module qmeg_queue
  import qmeg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  output logic  valid,
  output desc_t data,
  input  logic  pop
);

  desc_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hw/rtl/qmeg_hmean.sv
// ----------------------------------------------------------------------------
// qmeg_hmean: harmonic mean of four corner values
// One shared 32x32 multiplier builds abcd and ab(c+d)+cd(a+b), then a
// restoring divider divides 4abcd by the latter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module qmeg_hmean
  import qmeg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [PermW-1:0] a,
  input  logic [PermW-1:0] b,
  input  logic [PermW-1:0] c,
  input  logic [PermW-1:0] d,
  output logic             done,
  output logic [PermW-1:0] q
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;

  state_t        state;
  logic [3:0]    step;
  logic [4:0]    bit_cnt;
  logic [31:0]   a_r, b_r, c_r, d_r;
  logic [32:0]   s1, s2;
  logic [63:0]   ab, cd, prod;
  logic [97:0]   den;
  logic [127:0]  num;
  logic [129:0]  rem;
  logic [128:0]  dsr;
  logic [31:0]   op_x, op_y;
  logic [129:0]  diff;
  logic          fits;

  // Multiplier operand selection by step.
  always_comb begin
    case (step)
      4'd0:    begin op_x = a_r;        op_y = b_r;        end
      4'd1:    begin op_x = c_r;        op_y = d_r;        end
      4'd2:    begin op_x = ab[31:0];   op_y = s1[31:0];   end
      4'd3:    begin op_x = ab[63:32];  op_y = s1[31:0];   end
      4'd4:    begin op_x = cd[31:0];   op_y = s2[31:0];   end
      4'd5:    begin op_x = cd[63:32];  op_y = s2[31:0];   end
      4'd6:    begin op_x = ab[31:0];   op_y = cd[31:0];   end
      4'd7:    begin op_x = ab[31:0];   op_y = cd[63:32];  end
      4'd8:    begin op_x = ab[63:32];  op_y = cd[31:0];   end
      4'd9:    begin op_x = ab[63:32];  op_y = cd[63:32];  end
      default: begin op_x = 32'd0;      op_y = 32'd0;      end
    endcase
  end

  assign diff = rem - {1'b0, dsr};
  assign fits = (rem >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      step    <= 4'd0;
      bit_cnt <= 5'd0;
    end else begin
      done <= (state == S_DIV) && (bit_cnt == 5'd31);
      case (state)
        S_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            c_r   <= c;
            d_r   <= d;
            s1    <= {1'b0, c} + {1'b0, d};
            s2    <= {1'b0, a} + {1'b0, b};
            den   <= '0;
            num   <= '0;
            step  <= 4'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= op_x * op_y;
          step <= step + 4'd1;
          // Fold in the product of the previous step.
          case (step)
            4'd1:  ab  <= prod;
            4'd2:  cd  <= prod;
            4'd3:  den <= den + {34'd0, prod};
            4'd4:  den <= den + {2'd0, prod, 32'd0};
            4'd5:  den <= den + {34'd0, prod};
            4'd6:  den <= den + {2'd0, prod, 32'd0};
            4'd7:  num <= num + {64'd0, prod};
            4'd8:  num <= num + {32'd0, prod, 32'd0};
            4'd9:  num <= num + {32'd0, prod, 32'd0};
            4'd10: num <= num + {prod, 64'd0};
            4'd11: if (s1[32]) den <= den + {2'd0, ab, 32'd0};
            4'd12: if (s2[32]) den <= den + {2'd0, cd, 32'd0};
            4'd13: begin
              rem     <= {num, 2'b00};
              dsr     <= {den, 31'd0};
              bit_cnt <= 5'd0;
              state   <= S_DIV;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (fits) rem <= diff;
          q       <= {q[30:0], fits};
          dsr     <= {1'b0, dsr[128:1]};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd31) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `QMEG_ASSERT(a_start_idle, start |-> state == S_IDLE, "hmean started while busy")
  `QMEG_ASSERT(a_den_nonzero, state == S_DIV |-> den != 98'd0, "zero divisor")
  `QMEG_ASSERT(a_mean_bound, done |-> (q <= a_r || q <= b_r || q <= c_r || q <= d_r),
               "mean above largest corner")

endmodule

// File: hw/rtl/qmeg_front.sv
// ----------------------------------------------------------------------------
// qmeg_front: scan position, configuration and element classification
// Holds the grid registers and the raster counters and builds the element
// record for each accepted beat.
// ----------------------------------------------------------------------------
module qmeg_front
  import qmeg_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [10:0] cfg_data,
  qmeg_in_if.sink    elem_in,
  input  logic       q_full,
  output logic       push,
  output desc_t      push_data
);

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  logic [10:0]    grid_rows, grid_cols;
  logic           harmonic_mode;
  logic [RW-1:0]  rows_c, row_counter, row_inc;
  logic [CW-1:0]  cols_c, col_counter, col_inc;
  logic [IdW-1:0] element_counter, row_base, cols20, span, j20;
  logic           top, bottom, left, right;
  logic [3:0]     f0, f1, f2, f3;
  meta_t          meta;

  function automatic logic [IdW-1:0] vid(input logic r1, input logic r2,
                                         input logic [IdW-1:0] n,
                                         input logic [IdW-1:0] base);
    logic [IdW-1:0] v;
    if (r1) v = (n == 20'd1) ? 20'd0 : (n << 1) - 20'd1;
    else if (r2) v = (n <= 20'd2) ? n : (n << 1) - 20'd2;
    else v = base + n - 20'd1;
    return v;
  endfunction

  always_comb begin
    if (grid_rows < 11'd2) rows_c = RW'(2);
    else if ({21'd0, grid_rows} > 32'(MAX_ROWS)) rows_c = RW'(MAX_ROWS);
    else rows_c = RW'(grid_rows);
    if (grid_cols < 11'd2) cols_c = CW'(2);
    else if ({21'd0, grid_cols} > 32'(MAX_COLS)) cols_c = CW'(MAX_COLS);
    else cols_c = CW'(grid_cols);
  end

  assign row_inc = row_counter + RW'(1);
  assign col_inc = col_counter + CW'(1);
  assign cols20  = IdW'(cols_c);
  assign span    = cols20 - 20'd1;
  assign j20     = IdW'(col_counter);

  assign top    = (row_counter == RW'(1));
  assign bottom = (row_inc == rows_c);
  assign left   = (col_counter == CW'(1));
  assign right  = (col_inc == cols_c);

  always_comb begin
    f0 = (bottom && left) ? FLAG_LL : left ? FLAG_LEFT : bottom ? FLAG_BOTTOM : FLAG_NONE;
    f1 = (bottom && right) ? FLAG_LR : right ? FLAG_RIGHT : bottom ? FLAG_BOTTOM : FLAG_NONE;
    f2 = (top && right) ? FLAG_UR : right ? FLAG_RIGHT : top ? FLAG_TOP : FLAG_NONE;
    f3 = (top && left) ? FLAG_UL : left ? FLAG_LEFT : top ? FLAG_TOP : FLAG_NONE;

    meta.element_id         = element_counter;
    meta.vertex_lower_left  = vid(1'b0, top, j20, row_base + cols20);
    meta.vertex_lower_right = vid(1'b0, top, j20 + 20'd1, row_base + cols20);
    meta.vertex_upper_right = vid(top, row_counter == RW'(2), j20 + 20'd1, row_base);
    meta.vertex_upper_left  = vid(top, row_counter == RW'(2), j20, row_base);
    meta.node_flags         = {f3, f2, f1, f0};
    meta.outside_mask       = {left, top, right, bottom};
    meta.neighbour_bottom   = bottom ? 20'd0 : element_counter + span;
    meta.neighbour_right    = right ? 20'd0 : element_counter + 20'd1;
    meta.neighbour_top      = top ? 20'd0 : element_counter - span;
    meta.neighbour_left     = left ? 20'd0 : element_counter - 20'd1;
  end

  assign elem_in.ready = !q_full;
  assign push          = elem_in.valid && !q_full;

  always_comb begin
    push_data.meta     = meta;
    push_data.harmonic = harmonic_mode;
    push_data.ul       = elem_in.perm_upper_left;
    push_data.ll       = elem_in.perm_lower_left;
    push_data.lr       = elem_in.perm_lower_right;
    push_data.ur       = elem_in.perm_upper_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows       <= 11'd2;
      grid_cols       <= 11'd2;
      harmonic_mode   <= 1'b0;
      row_counter     <= RW'(1);
      col_counter     <= CW'(1);
      element_counter <= '0;
      row_base        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS, REG_GRID_COLS: begin
          if (cfg_index == REG_GRID_ROWS) grid_rows <= cfg_data;
          else grid_cols <= cfg_data;
          row_counter     <= RW'(1);
          col_counter     <= CW'(1);
          element_counter <= '0;
          row_base        <= '0;
        end
        REG_HARMONIC_MODE: harmonic_mode <= cfg_data[0];
        default: ;
      endcase
    end else if (push) begin
      if (right && bottom) begin
        // Last element of the grid: wrap to the first.
        col_counter     <= CW'(1);
        row_counter     <= RW'(1);
        row_base        <= '0;
        element_counter <= '0;
      end else if (right) begin
        col_counter     <= CW'(1);
        row_counter     <= row_inc;
        row_base        <= row_base + cols20;
        element_counter <= element_counter + 20'd1;
      end else begin
        col_counter     <= col_inc;
        element_counter <= element_counter + 20'd1;
      end
    end
  end

endmodule

// File: hw/rtl/qmeg_back.sv
// ----------------------------------------------------------------------------
// qmeg_back: permeability selection and output register
// Takes descriptors from the queue, runs the harmonic mean when needed and
// holds the finished record until the sink takes it.
// ----------------------------------------------------------------------------
module qmeg_back
  import qmeg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  desc_t       q_data,
  output logic        q_pop,
  qmeg_out_if.source  elem_out
);

  typedef enum logic [1:0] {B_IDLE, B_CALC, B_WAIT} state_t;

  state_t           state;
  meta_t            meta_r, out_meta;
  logic [PermW-1:0] out_perm;
  logic             out_valid;
  logic             out_free;
  logic             out_load;
  logic             any_zero;
  logic             hm_start, hm_done;
  logic [PermW-1:0] hm_q;

  assign out_free = !out_valid || elem_out.ready;
  assign any_zero = (q_data.ul == '0) || (q_data.ll == '0) ||
                    (q_data.lr == '0) || (q_data.ur == '0);
  assign q_pop    = (state == B_IDLE) && q_valid && out_free;
  assign hm_start = q_pop && q_data.harmonic && !any_zero;
  // The output register takes a record straight from the queue or from
  // the finished harmonic mean.
  assign out_load = (q_pop && !hm_start) ||
                    (((state == B_CALC) && hm_done) || (state == B_WAIT)) && out_free;

  qmeg_hmean u_hmean (
    .clk   (clk),
    .rst   (rst),
    .start (hm_start),
    .a     (q_data.ul),
    .b     (q_data.ll),
    .c     (q_data.lr),
    .d     (q_data.ur),
    .done  (hm_done),
    .q     (hm_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (elem_out.ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            if (hm_start) begin
              meta_r <= q_data.meta;
              state  <= B_CALC;
            end else begin
              out_meta <= q_data.meta;
              out_perm <= q_data.harmonic ? '0 : q_data.ll;
            end
          end
        end
        B_CALC, B_WAIT: begin
          if (hm_done || state == B_WAIT) begin
            if (out_free) begin
              out_meta <= meta_r;
              out_perm <= hm_q;
              state    <= B_IDLE;
            end else begin
              state <= B_WAIT;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign elem_out.valid              = out_valid;
  assign elem_out.element_id         = out_meta.element_id;
  assign elem_out.element_perm       = out_perm;
  assign elem_out.vertex_lower_left  = out_meta.vertex_lower_left;
  assign elem_out.vertex_lower_right = out_meta.vertex_lower_right;
  assign elem_out.vertex_upper_right = out_meta.vertex_upper_right;
  assign elem_out.vertex_upper_left  = out_meta.vertex_upper_left;
  assign elem_out.node_flags         = out_meta.node_flags;
  assign elem_out.outside_mask       = out_meta.outside_mask;
  assign elem_out.neighbour_bottom   = out_meta.neighbour_bottom;
  assign elem_out.neighbour_right    = out_meta.neighbour_right;
  assign elem_out.neighbour_top      = out_meta.neighbour_top;
  assign elem_out.neighbour_left     = out_meta.neighbour_left;

endmodule

// File: hw/rtl/quad_mesh_element_generator.sv
// ----------------------------------------------------------------------------
// quad_mesh_element_generator: quadrilateral element records from a pixel grid
// Walks the elements of a node grid in raster order and emits one record
// per element with ids, boundary flags, neighbours and permeability.
// ----------------------------------------------------------------------------
// Usage. Each beat on elem_in carries the four corner permeabilities of the
// next element in raster order; each beat on elem_out carries that element's
// record. One record leaves for every beat taken, in the same order.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block
// is idle. Writing grid_rows or grid_cols restarts the scan at element 0;
// the scan also wraps to element 0 after the last element of the grid.
// Flow. In lower-left mode, and in harmonic mode when a corner is zero, a
// beat is written into the queue and then into the output register, and
// the block sustains one beat per cycle while the sink keeps ready high.
// In harmonic mode the shared 32x32 multiplier and then the restoring
// divider work on one element at a time; the front end keeps accepting
// into a two-entry queue meanwhile.
// Reset clears the scan counters, the queue and the output register and
// sets the grid to 2 x 2 in lower-left mode. When the sink holds ready low,
// the record waits in the output register, the back end stops at the queue,
// and elem_in.ready falls once the queue fills.
// ----------------------------------------------------------------------------
module quad_mesh_element_generator
  import qmeg_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  qmeg_in_if.sink     elem_in,
  qmeg_out_if.source  elem_out
);

  // Front end to queue, queue to back end.
  logic  push, q_full, q_valid, q_pop;
  desc_t push_data, q_data;

  qmeg_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .elem_in   (elem_in),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  qmeg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .valid     (q_valid),
    .data      (q_data),
    .pop       (q_pop)
  );

  qmeg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .elem_out (elem_out)
  );

endmodule

// File: tb/sv/quad_mesh_element_generator_test.sv
// ----------------------------------------------------------------------------
// quad_mesh_element_generator_test: element record stream check
// Feeds corner permeabilities through the input channel under several grid
// shapes and both permeability modes. A predictor in this file tracks the
// raster scan and works out every element record. The records that leave
// the block are compared with it field by field, while both sides idle at random.
// ----------------------------------------------------------------------------
module quad_mesh_element_generator_test;
  import qmeg_pkg::*;

  localparam int GridMax = 1024;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [1:0] REG_SPARE = 2'd3;
  // Cycles to let pass after the last record. A harmonic element goes through
  // the multiplier and then the divider, and two more may wait in the queue.
  localparam int SettleCycles = 200;

  typedef struct packed {
    logic [31:0] c_ul;
    logic [31:0] c_ll;
    logic [31:0] c_lr;
    logic [31:0] c_ur;
  } corners_t;

  typedef struct packed {
    meta_t       meta;
    logic [31:0] perm;
  } element_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  qmeg_in_if  in_ch ();
  qmeg_out_if out_ch ();

  quad_mesh_element_generator dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .elem_in(in_ch),
    .elem_out(out_ch)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Corner sets waiting for the driver, and element records that the
  // block still owes us, oldest first.
  corners_t     corner_queue[$];
  element_rec_t owed_records[$];

  int mismatches = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  // Predictor copy of the registers and of the scan position.
  logic [10:0] rows_reg, cols_reg;
  logic        harmonic_reg;
  int unsigned scan_row, scan_col, scan_id;

  // Exact floor of 4abcd / (bcd + acd + abd + abc), zero if any corner is.
  function automatic logic [31:0] harmonic_perm(logic [31:0] a, logic [31:0] b,
                                                logic [31:0] c, logic [31:0] d);
    logic [159:0] num, den, part;
    if (a == 0 || b == 0 || c == 0 || d == 0) return 32'd0;
    num = a; num = num * b; num = num * c; num = num * d; num = num * 4;
    part = b; part = part * c; part = part * d; den = part;
    part = a; part = part * c; part = part * d; den = den + part;
    part = a; part = part * b; part = part * d; den = den + part;
    part = a; part = part * b; part = part * c; den = den + part;
    part = num / den;
    return part[31:0];
  endfunction

  // Node numbering of the file format: the first two rows are interleaved,
  // rows from the third on follow plain raster order.
  function automatic logic [19:0] node_number(int unsigned m, int unsigned n,
                                              int unsigned cols);
    longint unsigned v;
    if (m == 1) v = (n == 1) ? 1 : 2 * n;
    else if (m == 2) v = (n <= 2) ? n + 1 : 2 * n - 1;
    else v = longint'(m - 1) * cols + n;
    v = v - 1;
    return v[19:0];
  endfunction

  function automatic int unsigned clamp_grid(logic [10:0] v);
    if (v < 2) return 2;
    if (v > GridMax) return GridMax;
    return v;
  endfunction

  // Works out the record of the element at the current scan position and
  // then steps the scan, wrapping at the end of the grid.
  function automatic element_rec_t next_element(corners_t c);
    element_rec_t r;
    int unsigned rows, cols, span;
    logic top, bottom, left, right;
    logic [3:0] f0, f1, f2, f3;
    rows = clamp_grid(rows_reg);
    cols = clamp_grid(cols_reg);
    span = cols - 1;
    top = (scan_row == 1);
    bottom = (scan_row == rows - 1);
    left = (scan_col == 1);
    right = (scan_col == cols - 1);

    r.perm = harmonic_reg ? harmonic_perm(c.c_ul, c.c_ll, c.c_lr, c.c_ur) : c.c_ll;
    r.meta.element_id = scan_id[19:0];
    r.meta.vertex_lower_left = node_number(scan_row + 1, scan_col, cols);
    r.meta.vertex_lower_right = node_number(scan_row + 1, scan_col + 1, cols);
    r.meta.vertex_upper_right = node_number(scan_row, scan_col + 1, cols);
    r.meta.vertex_upper_left = node_number(scan_row, scan_col, cols);

    // Side edges win over top and bottom; grid corners get codes of their own.
    f0 = (bottom && left) ? FLAG_LL : left ? FLAG_LEFT : bottom ? FLAG_BOTTOM : FLAG_NONE;
    f1 = (bottom && right) ? FLAG_LR : right ? FLAG_RIGHT : bottom ? FLAG_BOTTOM : FLAG_NONE;
    f2 = (top && right) ? FLAG_UR : right ? FLAG_RIGHT : top ? FLAG_TOP : FLAG_NONE;
    f3 = (top && left) ? FLAG_UL : left ? FLAG_LEFT : top ? FLAG_TOP : FLAG_NONE;
    r.meta.node_flags = {f3, f2, f1, f0};
    r.meta.outside_mask = {left, top, right, bottom};
    r.meta.neighbour_bottom = bottom ? 20'd0 : 20'(scan_id + span);
    r.meta.neighbour_right = right ? 20'd0 : 20'(scan_id + 1);
    r.meta.neighbour_top = top ? 20'd0 : 20'(scan_id - span);
    r.meta.neighbour_left = left ? 20'd0 : 20'(scan_id - 1);

    scan_col = scan_col + 1;
    scan_id = (scan_id + 1) & 32'hFFFFF;
    if (scan_col >= cols) begin
      scan_col = 1;
      scan_row = scan_row + 1;
      if (scan_row >= rows) begin
        scan_row = 1;
        scan_id = 0;
      end
    end
    return r;
  endfunction

  // Input driver: a beat stays on the bus until it is taken, and a new one
  // is offered only when the sender is not idling this cycle.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (corner_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        corners_t c;
        c = corner_queue.pop_front();
        in_ch.perm_upper_left <= c.c_ul;
        in_ch.perm_lower_left <= c.c_ll;
        in_ch.perm_lower_right <= c.c_lr;
        in_ch.perm_upper_right <= c.c_ur;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Every beat the block takes owes us one record.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      owed_records.push_back(next_element({in_ch.perm_upper_left, in_ch.perm_lower_left,
                                           in_ch.perm_lower_right, in_ch.perm_upper_right}));
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Output monitor: checks each record taken against the oldest owed one
  // and stalls the sink at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record for element %0h arrived with none owed", out_ch.element_id);
        end else begin
          element_rec_t w;
          w = owed_records.pop_front();
          check_field("element_id", 32'(w.meta.element_id), 32'(out_ch.element_id));
          check_field("element_perm", w.perm, out_ch.element_perm);
          check_field("vertex_lower_left", 32'(w.meta.vertex_lower_left),
                      32'(out_ch.vertex_lower_left));
          check_field("vertex_lower_right", 32'(w.meta.vertex_lower_right),
                      32'(out_ch.vertex_lower_right));
          check_field("vertex_upper_right", 32'(w.meta.vertex_upper_right),
                      32'(out_ch.vertex_upper_right));
          check_field("vertex_upper_left", 32'(w.meta.vertex_upper_left),
                      32'(out_ch.vertex_upper_left));
          check_field("node_flags", 32'(w.meta.node_flags), 32'(out_ch.node_flags));
          check_field("outside_mask", 32'(w.meta.outside_mask), 32'(out_ch.outside_mask));
          check_field("neighbour_bottom", 32'(w.meta.neighbour_bottom),
                      32'(out_ch.neighbour_bottom));
          check_field("neighbour_right", 32'(w.meta.neighbour_right),
                      32'(out_ch.neighbour_right));
          check_field("neighbour_top", 32'(w.meta.neighbour_top),
                      32'(out_ch.neighbour_top));
          check_field("neighbour_left", 32'(w.meta.neighbour_left),
                      32'(out_ch.neighbour_left));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Register write; only called while the block is idle, so the predictor
  // can take the new value at once. Grid writes restart the scan.
  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_GRID_ROWS, REG_GRID_COLS: begin
        if (idx == REG_GRID_ROWS) rows_reg = val;
        else cols_reg = val;
        scan_row = 1;
        scan_col = 1;
        scan_id = 0;
      end
      REG_HARMONIC_MODE: harmonic_reg = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every beat is taken and every record has come back, then
  // gives a harmonic element still in flight time to leave.
  task automatic drain();
    while (corner_queue.size() > 0 || in_ch.valid || owed_records.size() > 0)
      @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random corner value; zeros come at the given rate and small values now
  // and then, so that the harmonic divider sees narrow operands as well.
  function automatic logic [31:0] random_corner(int zero_pct);
    if ($urandom_range(99) < zero_pct) return 32'd0;
    if ($urandom_range(3) == 0) return $urandom_range(65535, 1);
    return $urandom;
  endfunction

  task automatic queue_random(int count, int zero_pct);
    corners_t c;
    repeat (count) begin
      c.c_ul = random_corner(zero_pct);
      c.c_ll = random_corner(zero_pct);
      c.c_lr = random_corner(zero_pct);
      c.c_ur = random_corner(zero_pct);
      corner_queue.push_back(c);
    end
  endtask

  function automatic logic [10:0] random_size();
    case ($urandom_range(9))
      0: return 11'($urandom_range(1));            // below the range, acts as 2
      1: return 11'd2047;                          // above the range, clamped
      2: return 11'd1024;
      default: return 11'($urandom_range(8, 2));
    endcase
  endfunction

  initial begin
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_GRID_ROWS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.perm_upper_left = '0;
    in_ch.perm_lower_left = '0;
    in_ch.perm_lower_right = '0;
    in_ch.perm_upper_right = '0;
    out_ch.ready = 1'b0;
    rows_reg = 11'd2;
    cols_reg = 11'd2;
    harmonic_reg = 1'b0;
    scan_row = 1;
    scan_col = 1;
    scan_id = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset grid is a single element, so every beat wraps back to id 0.
    corner_queue.push_back({32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000});
    corner_queue.push_back({32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF});
    drain();

    // A 3 x 4 node grid has edge and corner elements, and its
    // second element row reaches node rows past the interleaved pair.
    write_reg(REG_GRID_ROWS, 11'd3);
    write_reg(REG_GRID_COLS, 11'd4);
    corner_queue.push_back({32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000});
    corner_queue.push_back({32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
    corner_queue.push_back({32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001});
    drain();
    write_reg(REG_HARMONIC_MODE, 11'd1);
    // The scan carries on from the fourth element; harmonic mode does not
    // restart it. Zero corners in each position force a zero result.
    corner_queue.push_back({32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
    corner_queue.push_back({32'h00000001, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF});
    corner_queue.push_back({32'h00000000, 32'h00010000, 32'h00010000, 32'h00010000});
    corner_queue.push_back({32'h00010000, 32'h00000000, 32'h00010000, 32'h00010000});
    corner_queue.push_back({32'h00010000, 32'h00010000, 32'h00000000, 32'h00010000});
    corner_queue.push_back({32'h00010000, 32'h00010000, 32'h00010000, 32'h00000000});
    corner_queue.push_back({32'h00000001, 32'h00000002, 32'h00000003, 32'h00000004});
    corner_queue.push_back({32'h80000000, 32'h00000001, 32'h7FFFFFFF, 32'h00000003});
    drain();

    // Out-of-range sizes and the largest grid, plus a write to the spare
    // index that must leave everything as it was.
    write_reg(REG_GRID_ROWS, 11'd0);
    write_reg(REG_GRID_COLS, 11'd2047);
    write_reg(REG_SPARE, 11'h7FF);
    write_reg(REG_HARMONIC_MODE, 11'd0);
    queue_random(6, 10);
    drain();
    write_reg(REG_GRID_ROWS, 11'd1024);
    write_reg(REG_GRID_COLS, 11'd1);
    queue_random(6, 10);
    drain();

    // Random part: a fresh grid and mode per phase, cycling through the
    // idling patterns so gaps land on every stage of the pipeline.
    for (phase = 0; phase < 20; phase++) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
        default: begin src_idle_pct = 25; sink_stall_pct = 25; end
      endcase
      write_reg(REG_GRID_ROWS, random_size());
      write_reg(REG_GRID_COLS, random_size());
      write_reg(REG_HARMONIC_MODE, 11'($urandom_range(1)));
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, 11'($urandom));
      queue_random(34, 8);
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(8 * 2000000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/qmeg_pkg.sv
hw/rtl/qmeg_if.sv
hw/rtl/qmeg_queue.sv
hw/rtl/qmeg_hmean.sv
hw/rtl/qmeg_front.sv
hw/rtl/qmeg_back.sv
hw/rtl/quad_mesh_element_generator.sv
tb/sv/quad_mesh_element_generator_test.sv
